[rtl/sstq_pkg.sv]
`default_nettype none

package sstq_pkg;

    localparam int ID_W        = 16;
    localparam int TIME_W      = 32;
    localparam int TPS_W       = 20;
    localparam int SECS_W      = 16;
    localparam int MAX_RESULTS = 32;

    localparam logic [TPS_W-1:0]  TPS_RESET = 20'd1000000;
    localparam logic [TIME_W-1:0] TIME_MAX  = 32'hFFFF_FFFF;

    localparam logic MODE_SLEEP = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WOKEN  = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_NEG  = 2'd1;
    localparam logic [1:0] STATUS_BUSY = 2'd2;

endpackage

`default_nettype wire

[rtl/sorted_sleep_timer_queue.sv]
`default_nettype none

// Sorted sleep timer queue.
// An item is taken when start is high and busy is low; i_mode selects a sleep
// request or a clock tick. Each result shows on the o_ result ports for one
// cycle with o_valid high, and the receiver takes it in that cycle.
// A sleep request gives one status result. A negative duration answers in
// the cycle after the request. Otherwise a reciprocal-multiply remainder
// unit finds the slot, the slot is checked, and the insertion walks the
// sorted list from its tail, moving each later entry with one memory read
// and one write back, then places the new entry.
// A tick releases due entries from the head of the list, at most 32 per
// tick, reading and comparing the head for each entry; the final result
// carries o_last and shows as busy falls.
// The ticks-per-second register is written over its own valid/ready channel,
// which is always ready; write it only while busy is low.
// Reset clears the waiting flags, list pointers and count and loads the
// register with one million; the list memory itself is not cleared.
module sorted_sleep_timer_queue #(
    parameter int SLOT_COUNT = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_mode,
    input  wire logic [sstq_pkg::ID_W-1:0]     i_process_id,
    input  wire logic signed [sstq_pkg::SECS_W-1:0] i_sleep_seconds,
    input  wire logic [sstq_pkg::TIME_W-1:0]   i_now,
    output logic                               o_valid,
    output logic                               o_kind,
    output logic [1:0]                         o_status,
    output logic [sstq_pkg::ID_W-1:0]          o_woken_id,
    output logic                               o_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sstq_pkg::TPS_W-1:0]    i_cfg_data
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int DEPTH = 1 << SW;
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int NW    = $clog2(sstq_pkg::MAX_RESULTS + 1);
    localparam int PW    = sstq_pkg::SECS_W - 1 + sstq_pkg::TPS_W;
    localparam int SUMW  = PW + 1;

    typedef struct packed {
        logic [sstq_pkg::TIME_W-1:0] wake;
        logic [sstq_pkg::ID_W-1:0]   id;
        logic [SW-1:0]               slot;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CHK,
        S_IRD,
        S_ICMP,
        S_TRD,
        S_TCMP
    } t_state;

    t_state                       r_state;
    logic [sstq_pkg::TPS_W-1:0]   r_tps;
    logic [sstq_pkg::ID_W-1:0]    r_pid;
    logic [sstq_pkg::TIME_W-1:0]  r_now;
    logic [PW-1:0]                r_prod;
    logic [sstq_pkg::TIME_W-1:0]  r_wake;
    logic [SW-1:0]                r_slot;
    logic [SLOT_COUNT-1:0]        r_waiting;
    logic [SW-1:0]                r_hd;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                r_k;
    logic [NW-1:0]                r_n;
    logic                         r_pend_v;
    logic [sstq_pkg::ID_W-1:0]    r_pend_id;
    logic                         r_valid;
    logic                         r_kind;
    logic [1:0]                   r_status;
    logic [sstq_pkg::ID_W-1:0]    r_out_id;
    logic                         r_last;

    t_entry                       r_mem [DEPTH];
    t_entry                       r_rd;
    logic [SW-1:0]                n_ra;
    logic [SW-1:0]                n_wa;
    logic                         n_we;
    t_entry                       n_wd;
    t_entry                       n_new;
    logic [SUMW-1:0]              n_sum;
    logic                         n_due;
    logic                         n_tick_end;

    logic                         n_mod_start;
    logic                         w_mod_done;
    logic [SW-1:0]                w_mod_rem;

    assign n_mod_start = (r_state == S_IDLE) && start && (i_mode == sstq_pkg::MODE_SLEEP)
                         && !i_sleep_seconds[sstq_pkg::SECS_W-1];

    sstq_slot_mod #(
        .DIVISOR (SLOT_COUNT)
    ) u_slot_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_mod_start),
        .i_dividend (i_process_id),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign n_sum = {{(SUMW - sstq_pkg::TIME_W){1'b0}}, r_now} + {1'b0, r_prod};
    assign n_new = '{wake: r_wake, id: r_pid, slot: r_slot};
    assign n_due = (r_rd.wake <= r_now);
    assign n_tick_end = (r_cnt == '0) || (r_n == NW'(sstq_pkg::MAX_RESULTS));

    // Memory port control: the insertion reads one entry below the hole and
    // writes either that entry into the hole or the new entry.
    always_comb begin
        n_ra = r_hd;
        n_wa = r_hd + r_k[SW-1:0];
        n_we = 1'b0;
        n_wd = n_new;
        case (r_state)
            S_IRD: begin
                n_ra = r_hd + SW'(r_k - 1'b1);
                n_we = (r_k == '0);
            end
            S_ICMP: begin
                n_we = 1'b1;
                if (r_rd.wake > r_wake) begin
                    n_wd = r_rd;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_wa] <= n_wd;
        end
        r_rd <= r_mem[n_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tps     <= sstq_pkg::TPS_RESET;
            r_waiting <= '0;
            r_hd      <= '0;
            r_cnt     <= '0;
            r_valid   <= 1'b0;
            r_pend_v  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tps <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_pid  <= i_process_id;
                        r_now  <= i_now;
                        r_prod <= PW'(i_sleep_seconds[sstq_pkg::SECS_W-2:0]) * PW'(r_tps);
                        r_n      <= '0;
                        r_pend_v <= 1'b0;
                        if (i_mode == sstq_pkg::MODE_TICK) begin
                            r_state <= S_TRD;
                        end else if (i_sleep_seconds[sstq_pkg::SECS_W-1]) begin
                            r_valid  <= 1'b1;
                            r_kind   <= sstq_pkg::KIND_STATUS;
                            r_status <= sstq_pkg::STATUS_NEG;
                            r_out_id <= i_process_id;
                            r_last   <= 1'b1;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (n_sum[SUMW-1:sstq_pkg::TIME_W] != '0) begin
                        r_wake <= sstq_pkg::TIME_MAX;
                    end else begin
                        r_wake <= n_sum[sstq_pkg::TIME_W-1:0];
                    end
                    if (w_mod_done) begin
                        r_slot  <= w_mod_rem;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_waiting[r_slot] || (r_cnt >= CW'(SLOT_COUNT))) begin
                        r_valid  <= 1'b1;
                        r_kind   <= sstq_pkg::KIND_STATUS;
                        r_status <= sstq_pkg::STATUS_BUSY;
                        r_out_id <= r_pid;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_waiting[r_slot] <= 1'b1;
                        r_k     <= r_cnt;
                        r_state <= S_IRD;
                    end
                end
                S_IRD: begin
                    if (r_k == '0) begin
                        r_cnt    <= r_cnt + 1'b1;
                        r_valid  <= 1'b1;
                        r_kind   <= sstq_pkg::KIND_STATUS;
                        r_status <= sstq_pkg::STATUS_OK;
                        r_out_id <= r_pid;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_ICMP;
                    end
                end
                S_ICMP: begin
                    if (r_rd.wake > r_wake) begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_IRD;
                    end else begin
                        r_cnt    <= r_cnt + 1'b1;
                        r_valid  <= 1'b1;
                        r_kind   <= sstq_pkg::KIND_STATUS;
                        r_status <= sstq_pkg::STATUS_OK;
                        r_out_id <= r_pid;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_TRD: begin
                    if (n_tick_end) begin
                        r_valid  <= r_pend_v;
                        r_kind   <= sstq_pkg::KIND_WOKEN;
                        r_status <= sstq_pkg::STATUS_OK;
                        r_out_id <= r_pend_id;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_TCMP;
                    end
                end
                S_TCMP: begin
                    // A released entry is held back one step so that the
                    // final one can be marked once the next head is known.
                    r_valid  <= r_pend_v;
                    r_kind   <= sstq_pkg::KIND_WOKEN;
                    r_status <= sstq_pkg::STATUS_OK;
                    r_out_id <= r_pend_id;
                    if (n_due) begin
                        r_last    <= 1'b0;
                        r_pend_v  <= 1'b1;
                        r_pend_id <= r_rd.id;
                        r_waiting[r_rd.slot] <= 1'b0;
                        r_hd    <= r_hd + 1'b1;
                        r_cnt   <= r_cnt - 1'b1;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_TRD;
                    end else begin
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_status    = r_status;
    assign o_woken_id  = r_out_id;
    assign o_last      = r_last;

endmodule

`default_nettype wire

[rtl/sstq_slot_mod.sv]
`default_nettype none

// Remainder of a process id by the slot count. A rounded-up reciprocal
// multiply gives the quotient, which is registered, and the remainder is
// then worked out from it and registered too.
module sstq_slot_mod #(
    parameter int DIVISOR = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [sstq_pkg::ID_W-1:0]    i_dividend,
    output logic                              o_done,
    output logic [$clog2(DIVISOR)-1:0]        o_rem
);

    localparam int SW  = $clog2(DIVISOR);
    localparam int XW  = sstq_pkg::ID_W;
    localparam int SH  = XW + SW;
    localparam int MW  = XW + 1;
    localparam int PRW = XW + MW;
    localparam int QW  = PRW - SH;
    // With the shift at dividend width plus the divisor's bit count, the
    // rounded-up reciprocal gives an exact quotient for every dividend.
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic               r_s1;
    logic               r_done;
    logic [XW-1:0]      r_x;
    logic [QW-1:0]      r_q;
    logic [SW-1:0]      r_rem;
    logic [PRW-1:0]     n_prod;
    logic [XW-1:0]      n_qd;

    assign n_prod = PRW'(i_dividend) * PRW'(RECIP);
    assign n_qd   = XW'(r_q) * XW'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_done <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
            r_q <= n_prod[PRW-1:SH];
        end
        if (r_s1) begin
            r_rem <= SW'(r_x - n_qd);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
